FILE: rtl/core/gsp_pkg.sv
// Shared widths and constants for the two-vector Gram-Schmidt pipeline.
`default_nettype none
package gsp_pkg;

    localparam int NUM_COMP = 4;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int COMP_W   = 35;
    localparam int T_W      = 32;
    localparam int Q30_ONE  = 1 << 30;

endpackage : gsp_pkg
`default_nettype wire

FILE: rtl/core/gram_schmidt_pair_4d.sv
// Top level: orthonormalises a pair of 4-component Q16.16 vectors into Q1.30.
//
// Input stream s_*: one transfer carries a and b (tdata: a_x..a_w, b_x..b_w, 32 bits
// each from bit 0). Output stream m_*: tdata carries u_x..u_w, v_x..v_w; tuser[0] is
// first_zero, tuser[1] is second_parallel. Every input transfer gives one output.
// One pair per cycle is sustained while m_tready does not stall the output. The
// path runs through two unit-vector stages, whose exact root ratio resolves one
// result bit per pipeline stage, plus four stages for the projection and one
// output register.
// The pipeline moves as a whole: while m_tvalid is high and m_tready low, every
// stage holds and s_tready is low; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; results in flight are lost.
// LANES below four zeroes the upper components of u and v and ignores those inputs.
`default_nettype none
module gram_schmidt_pair_4d
    import gsp_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // u_x, u_y, u_z, u_w, v_x, v_y, v_z, v_w
    output logic [1:0]   m_tuser    // first_zero, second_parallel
);

    localparam int B_W  = IN_W * LANES;
    localparam int P_W  = 2 * IN_W;
    localparam int D_W  = P_W + 2;
    localparam int DQ_W = 36;
    localparam int PU_W = 68;
    localparam int RN_W = 40;

    function automatic logic signed [RN_W-1:0] rnd_q30(input logic signed [PU_W-1:0] x);
        logic [PU_W-1:0] mag;
        logic [PU_W-1:0] m;
        mag = x[PU_W-1] ? PU_W'(-x) : PU_W'(x);
        m   = (mag + (PU_W'(1) << 29)) >> 30;
        return x[PU_W-1] ? -RN_W'(m) : RN_W'(m);
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // first unit vector
    logic signed [COMP_W-1:0] a_in  [LANES];
    logic signed [OUT_W-1:0]  ua_o  [LANES];
    logic                     ua_valid;
    logic                     ua_zero;
    logic [B_W-1:0]           ua_side;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            a_in[l] = COMP_W'($signed(s_tdata[IN_W*l +: IN_W]));
        end
    end

    gsp_unit #(.LANES(LANES), .SIDE_W(B_W)) u_unit_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_c     (a_in),
        .in_side  (s_tdata[IN_W*NUM_COMP +: B_W]),
        .out_valid(ua_valid),
        .out_o    (ua_o),
        .out_zero (ua_zero),
        .out_side (ua_side)
    );

    // projection of b on u and residual b minus projection
    logic signed [IN_W-1:0]   b1_reg [LANES];
    logic signed [IN_W-1:0]   b2_reg [LANES];
    logic signed [IN_W-1:0]   b3_reg [LANES];
    logic signed [OUT_W-1:0]  u1_reg [LANES];
    logic signed [OUT_W-1:0]  u2_reg [LANES];
    logic signed [OUT_W-1:0]  u3_reg [LANES];
    logic signed [P_W-1:0]    p_reg  [LANES];
    logic signed [PU_W-1:0]   pu_reg [LANES];
    logic signed [COMP_W-1:0] r_reg  [LANES];
    logic signed [DQ_W-1:0]   dq_reg;
    logic signed [D_W-1:0]    d_sum;
    logic [3:0]               fz_reg;
    logic [3:0]               vld_reg;
    logic [OUT_W*LANES-1:0]   u_pack_reg;

    always_comb begin
        d_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            d_sum = d_sum + D_W'(p_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], ua_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fz_reg <= {fz_reg[2:0], ua_zero};
            for (int l = 0; l < LANES; l++) begin
                b1_reg[l] <= $signed(ua_side[IN_W*l +: IN_W]);
                u1_reg[l] <= ua_o[l];
                p_reg[l]  <= P_W'($signed(ua_side[IN_W*l +: IN_W])) * P_W'(ua_o[l]);
                b2_reg[l] <= b1_reg[l];
                u2_reg[l] <= u1_reg[l];
                b3_reg[l] <= b2_reg[l];
                u3_reg[l] <= u2_reg[l];
                pu_reg[l] <= PU_W'(dq_reg) * PU_W'(u2_reg[l]);
                r_reg[l]  <= COMP_W'(RN_W'(b3_reg[l]) - rnd_q30(pu_reg[l]));
                u_pack_reg[OUT_W*l +: OUT_W] <= u3_reg[l];
            end
            dq_reg <= DQ_W'(rnd_q30(PU_W'(d_sum)));
        end
    end

    // second unit vector
    logic signed [OUT_W-1:0]  vb_o [LANES];
    logic                     vb_valid;
    logic                     vb_zero;
    logic [OUT_W*LANES:0]     vb_side;

    gsp_unit #(.LANES(LANES), .SIDE_W(OUT_W*LANES+1)) u_unit_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_reg[3]),
        .in_c     (r_reg),
        .in_side  ({fz_reg[3], u_pack_reg}),
        .out_valid(vb_valid),
        .out_o    (vb_o),
        .out_zero (vb_zero),
        .out_side (vb_side)
    );

    // output register
    logic [255:0] data_reg;
    logic [255:0] data_next;
    logic [1:0]   user_reg;
    logic         fz_out;
    logic         mval_reg;

    assign fz_out = vb_side[OUT_W*LANES];

    for (genvar l = 0; l < NUM_COMP; l++) begin : g_out
        if (l < LANES) begin : g_on
            assign data_next[OUT_W*l +: OUT_W] = vb_side[OUT_W*l +: OUT_W];
            assign data_next[OUT_W*(l+NUM_COMP) +: OUT_W] = fz_out ? '0 : vb_o[l];
        end else begin : g_off
            assign data_next[OUT_W*l +: OUT_W] = '0;
            assign data_next[OUT_W*(l+NUM_COMP) +: OUT_W] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (en) begin
            mval_reg <= vb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            user_reg <= {vb_zero && !fz_out, fz_out};
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    // checks
    a_zero_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("zero first vector with non-zero result");

    a_parallel_v: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[255:128] == '0)
        else $error("parallel flag with non-zero v");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !vld_reg[0])
        else $error("valid survives reset");

endmodule : gram_schmidt_pair_4d
`default_nettype wire

FILE: rtl/core/gsp_unit.sv
// Pipelined unit-vector stage: squares, sum, bit-per-stage exact root ratio, rounding.
`default_nettype none
module gsp_unit
    import gsp_pkg::*;
#(
    parameter int LANES  = 4,
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [COMP_W-1:0] in_c [LANES],
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [OUT_W-1:0]  out_o [LANES],
    output logic                     out_zero,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int SQ_W  = 2 * COMP_W;
    localparam int S_W   = SQ_W + $clog2(LANES);
    localparam int TS_W  = S_W + T_W;
    localparam int ACC_W = S_W + 2 * T_W + 2;
    localparam int STEPS = T_W;

    // squares
    logic [SQ_W-1:0]   sq_reg   [LANES];
    logic [SQ_W-1:0]   sq_next  [LANES];
    logic              neg1_reg [LANES];
    logic [SIDE_W-1:0] side1_reg;
    logic              vld1_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [COMP_W-1:0] mag;
            mag = in_c[l][COMP_W-1] ? COMP_W'(-in_c[l]) : COMP_W'(in_c[l]);
            sq_next[l] = SQ_W'(mag) * SQ_W'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                sq_reg[l]   <= sq_next[l];
                neg1_reg[l] <= in_c[l][COMP_W-1];
            end
            side1_reg <= in_side;
        end
    end

    // root iteration state, index 0 loaded from the squares
    logic [ACC_W-1:0]  rem_reg  [STEPS+1][LANES];
    logic [TS_W-1:0]   ts_reg   [STEPS+1][LANES];
    logic [T_W-1:0]    t_reg    [STEPS+1][LANES];
    logic              neg_reg  [STEPS+1][LANES];
    logic [S_W-1:0]    s_reg    [STEPS+1];
    logic [SIDE_W-1:0] side_reg [STEPS+1];
    logic              vld_reg  [STEPS+1];
    logic [S_W-1:0]    s_next;

    always_comb begin
        s_next = '0;
        for (int l = 0; l < LANES; l++) begin
            s_next = s_next + S_W'(sq_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= ACC_W'(sq_reg[l]) << (2 * T_W - 2);
                ts_reg[0][l]  <= '0;
                t_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg1_reg[l];
            end
            s_reg[0]    <= s_next;
            side_reg[0] <= side1_reg;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int K = STEPS - 1 - j;
        logic [ACC_W-1:0] trial [LANES];
        logic             take  [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = (ACC_W'(ts_reg[j][l]) << (K + 1)) + (ACC_W'(s_reg[j]) << (2 * K));
                take[l]  = trial[l] <= rem_reg[j][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[j+1][l] <= take[l] ? rem_reg[j][l] - trial[l] : rem_reg[j][l];
                    ts_reg[j+1][l]  <= take[l] ? ts_reg[j][l] + (TS_W'(s_reg[j]) << K)
                                               : ts_reg[j][l];
                    t_reg[j+1][l]   <= t_reg[j][l] | (T_W'(take[l]) << K);
                    neg_reg[j+1][l] <= neg_reg[j][l];
                end
                s_reg[j+1]    <= s_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    // round half up, clamp to one, apply sign, zero for a zero vector
    logic signed [OUT_W-1:0] o_reg  [LANES];
    logic signed [OUT_W-1:0] o_next [LANES];
    logic                    zero_reg;
    logic [SIDE_W-1:0]       side_o_reg;
    logic                    vld_o_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [T_W:0] q;
            q = (T_W+1)'((T_W+1)'(t_reg[STEPS][l]) + 1'b1) >> 1;
            if (q > (T_W+1)'(Q30_ONE)) begin
                q = (T_W+1)'(Q30_ONE);
            end
            if (s_reg[STEPS] == '0) begin
                o_next[l] = '0;
            end else if (neg_reg[STEPS][l]) begin
                o_next[l] = -OUT_W'(q);
            end else begin
                o_next[l] = OUT_W'(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o_reg <= 1'b0;
        end else if (en) begin
            vld_o_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_reg      <= o_next;
            zero_reg   <= s_reg[STEPS] == '0;
            side_o_reg <= side_reg[STEPS];
        end
    end

    assign out_valid = vld_o_reg;
    assign out_o     = o_reg;
    assign out_zero  = zero_reg;
    assign out_side  = side_o_reg;

endmodule : gsp_unit
`default_nettype wire
